[rtl/lbm_pkg.sv]
// ----------------------------------------------------------------------------
// lbm_pkg - shared types and constants for the LED bar meter
// Field widths, register indexes and the LED write job handed to the writer.
// ----------------------------------------------------------------------------
package lbm_pkg;

  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int COLOR_W = 24;
  localparam int VAL_W   = 16;
  localparam int TIME_W  = 32;
  localparam int PROD_W  = VAL_W + CNT_W;

  localparam int MUL_STEPS = CNT_W;
  localparam int DIV_STEPS = PROD_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_INDEX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR    = 2'd3;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [VAL_W-1:0]   val_t;

  localparam color_t BLACK_RGB = 24'h000000;

  typedef struct packed {
    idx_t   first;
    logic   up;
    cnt_t   span;
    cnt_t   lit;
    color_t fgc;
    color_t bgc;
  } wr_job_t;

endpackage

[rtl/lbm_lit_unit.sv]
// ----------------------------------------------------------------------------
// lbm_lit_unit - serial lit-count unit
// Shift-add multiply of value by span, one multiplier bit a cycle, then a
// restoring divide by max_value, one quotient bit a cycle, saturated at span.
// ----------------------------------------------------------------------------
module lbm_lit_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  lbm_pkg::val_t val,
  input  lbm_pkg::cnt_t span,
  input  lbm_pkg::val_t maxv,
  output logic          busy,
  output logic          done,
  output lbm_pkg::cnt_t lit
);
  import lbm_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]        phase;
  logic [4:0]        step;
  logic [PROD_W-1:0] mcand;
  cnt_t              mplier;
  logic [PROD_W-1:0] acc;
  val_t              rem;
  cnt_t              q;
  logic              ovf;
  cnt_t              span_r;
  val_t              maxv_r;

  logic [VAL_W:0] rem_sh;
  logic [VAL_W:0] rem_diff;
  logic           ge;

  assign rem_sh   = {rem, acc[PROD_W-1]};
  assign rem_diff = rem_sh - {1'b0, maxv_r};
  assign ge       = rem_sh >= {1'b0, maxv_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      step  <= '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase  <= PH_MUL;
            step   <= '0;
            mcand  <= {{(PROD_W-VAL_W){1'b0}}, val};
            mplier <= span;
            acc    <= '0;
            rem    <= '0;
            q      <= '0;
            ovf    <= 1'b0;
            span_r <= span;
            maxv_r <= maxv;
          end
        end
        PH_MUL: begin
          if (mplier[0]) acc <= acc + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          step   <= step + 5'd1;
          if (step == 5'(MUL_STEPS-1)) begin
            phase <= PH_DIV;
            step  <= '0;
          end
        end
        PH_DIV: begin
          // shift one dividend bit into the remainder, subtract if it fits
          rem  <= ge ? rem_diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
          acc  <= acc << 1;
          q    <= {q[CNT_W-2:0], ge};
          ovf  <= ovf | q[CNT_W-1];
          step <= step + 5'd1;
          if (step == 5'(DIV_STEPS-1)) phase <= PH_DONE;
        end
        PH_DONE: phase <= PH_IDLE;
        default: phase <= PH_IDLE;
      endcase
    end
  end

  assign busy = phase != PH_IDLE;
  assign done = phase == PH_DONE;
  assign lit  = (ovf || q > span_r) ? span_r : q;

  a_lit_in_span: assert property (@(posedge clk) disable iff (rst)
    done |-> lit <= span_r)
    else $error("lit count exceeds span");

endmodule

[rtl/lbm_led_writer.sv]
// ----------------------------------------------------------------------------
// lbm_led_writer - LED write sequencer
// Walks the span one LED a cycle unless stalled; drives output word register.
// ----------------------------------------------------------------------------
module lbm_led_writer (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lbm_pkg::wr_job_t job,
  output logic             busy,
  output logic             m_valid,
  input  logic             m_ready,
  output lbm_pkg::idx_t    m_index,
  output lbm_pkg::color_t  m_color,
  output logic             m_last
);
  import lbm_pkg::*;

  wr_job_t job_r;
  cnt_t    cnt;
  idx_t    pos;
  logic    load;
  logic    is_last;

  assign load    = busy && (!m_valid || m_ready);
  assign is_last = (cnt + cnt_t'(1)) == job_r.span;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (start) begin
        job_r <= job;
        pos   <= job.first;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (load) begin
        m_index <= pos;
        m_color <= (cnt < job_r.lit) ? job_r.fgc : job_r.bgc;
        m_last  <= is_last;
        pos     <= job_r.up ? pos + idx_t'(1) : pos - idx_t'(1);
        cnt     <= cnt + cnt_t'(1);
        if (is_last) busy <= 1'b0;
      end
      // hold the word until taken
      if (load) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("write job started while busy");

  a_cnt_in_span: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt < job_r.span)
    else $error("write counter ran past span");

endmodule

[rtl/led_bar_meter_with_flash_top.sv]
// An accepted word goes through ST_CALC, then ST_WAIT while lbm_lit_unit runs
// its 7 multiply steps and 23 divide steps, then ST_EMIT to start the writer;
// when blanked or max_value is zero, ST_CALC goes straight to ST_EMIT.
// The next word is accepted and computed while the writer drains the last
// refresh; ST_EMIT holds until the writer is free. Reset: rst synchronous;
// registers to defaults, blink shown.
// ----------------------------------------------------------------------------
// led_bar_meter_with_flash_top - LED bar graph meter with flashing
// Blink timing, span setup and sequencing around the lit unit and the writer.
// ----------------------------------------------------------------------------
module led_bar_meter_with_flash_top #(
  parameter int NUM_LEDS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // now_ms[31:0], meter_value[47:32], fg_color[71:48], flash_interval[87:72]
  input  logic [87:0]                      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // led_index[5:0], led_color[29:6], zero[31:30]
  output logic [31:0]                      m_axis_tdata,
  // last_write
  output logic                             m_axis_tlast
);
  import lbm_pkg::*;

  localparam int MAX_IDX = NUM_LEDS - 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  idx_t   start_index;
  idx_t   end_index;
  val_t   max_value;
  color_t background_color;

  logic [1:0]        state;
  logic              blink;
  logic [TIME_W-1:0] last_toggle;
  val_t              val_r;
  color_t            fg_r;
  logic              shown_r;
  idx_t              s_r;
  logic              up_r;
  cnt_t              span_r;
  cnt_t              lit_r;

  logic [TIME_W-1:0] now_ms;
  val_t              meter_value;
  color_t            fg_color;
  val_t              flash_interval;
  logic [TIME_W-1:0] elapsed;
  logic              toggle;
  logic              blink_next;
  idx_t              s_c;
  idx_t              e_c;
  logic              up_c;
  cnt_t              span_c;
  logic              accept;

  logic    lit_start;
  logic    lit_busy;
  logic    lit_done;
  cnt_t    lit_out;
  logic    wr_start;
  logic    wr_busy;
  wr_job_t job;
  idx_t    led_index;
  color_t  led_color;

  assign now_ms         = s_axis_tdata[31:0];
  assign meter_value    = s_axis_tdata[47:32];
  assign fg_color       = s_axis_tdata[71:48];
  assign flash_interval = s_axis_tdata[87:72];

  assign elapsed    = now_ms - last_toggle;
  assign toggle     = (flash_interval != '0) && (elapsed >= {16'd0, flash_interval});
  assign blink_next = blink ^ toggle;

  assign s_c    = (int'(start_index) > MAX_IDX) ? IDX_W'(MAX_IDX) : start_index;
  assign e_c    = (int'(end_index) > MAX_IDX) ? IDX_W'(MAX_IDX) : end_index;
  assign up_c   = s_c < e_c;
  assign span_c = up_c ? ({1'b0, e_c} - {1'b0, s_c} + cnt_t'(1))
                       : ({1'b0, s_c} - {1'b0, e_c} + cnt_t'(1));

  assign s_axis_tready = state == ST_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_index      <= '0;
      end_index        <= 6'd63;
      max_value        <= 16'd100;
      background_color <= BLACK_RGB;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_INDEX: start_index      <= cfg_data[IDX_W-1:0];
        CFG_END_INDEX:   end_index        <= cfg_data[IDX_W-1:0];
        CFG_MAX_VALUE:   max_value        <= cfg_data[VAL_W-1:0];
        CFG_BG_COLOR:    background_color <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign lit_start = (state == ST_CALC) && shown_r && (max_value != '0);
  assign wr_start  = (state == ST_EMIT) && !wr_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      blink       <= 1'b0;
      last_toggle <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (toggle) begin
              blink       <= blink_next;
              last_toggle <= now_ms;
            end
            shown_r <= (flash_interval == '0) || !blink_next;
            val_r   <= meter_value;
            fg_r    <= fg_color;
            s_r     <= s_c;
            up_r    <= up_c;
            span_r  <= span_c;
            state   <= ST_CALC;
          end
        end
        ST_CALC: begin
          priority if (!shown_r) begin
            lit_r <= '0;
            state <= ST_EMIT;
          end else if (max_value == '0) begin
            lit_r <= span_r;
            state <= ST_EMIT;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (lit_done) begin
            lit_r <= lit_out;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!wr_busy) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign job = '{first: s_r,
                 up:    up_r,
                 span:  span_r,
                 lit:   lit_r,
                 fgc:   shown_r ? fg_r : BLACK_RGB,
                 bgc:   shown_r ? background_color : BLACK_RGB};

  lbm_lit_unit u_lit (
    .clk   (clk),
    .rst   (rst),
    .start (lit_start),
    .val   (val_r),
    .span  (span_r),
    .maxv  (max_value),
    .busy  (lit_busy),
    .done  (lit_done),
    .lit   (lit_out)
  );

  lbm_led_writer u_writer (
    .clk     (clk),
    .rst     (rst),
    .start   (wr_start),
    .job     (job),
    .busy    (wr_busy),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_index (led_index),
    .m_color (led_color),
    .m_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, led_color, led_index};

  a_wait_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT |-> lit_busy)
    else $error("waiting on an idle lit unit");

endmodule
